[design/tdsr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the text display scroll refresher.
package tdsr_pkg;

  // Text store geometry
  localparam int ROWS      = 8;
  localparam int COLS      = 20;
  localparam int PITCH     = COLS + 1;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W     = $clog2(PITCH);
  localparam int CP_W      = $clog2(PITCH + 1);
  localparam int STEP_W    = $clog2(ROWS + 1);
  localparam int MEM_DEPTH = ROWS * PITCH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths
  localparam int ACT_W      = 2;
  localparam int SEL_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int LINE_W     = 3;
  localparam int SLOT_W     = 4;
  localparam int LINES_W    = 4;
  localparam int MODE_W     = 2;
  localparam int IVL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [LINES_W-1:0] MAX_LINES    = 4'd8;
  localparam logic [LINES_W-1:0] LINES_RST    = 4'd4;
  localparam logic [IVL_W-1:0]   INTERVAL_RST = 16'd3000;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'h20;

  // Scroll modes
  localparam logic [MODE_W-1:0] MODE_CONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROW  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALT  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_SELECT  = 2'd1,
    ACT_APPEND  = 2'd2,
    ACT_REFRESH = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_ACK    = 2'd3
  } kind_t;

  // Commands from the sequencer to the text store
  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              head_clr;
    logic              head_we;
    logic [ROW_W-1:0]  head_row;
    logic              head_val;
    logic              copy_we;
    logic              copy_zero;
    logic [COL_W-1:0]  copy_idx;
    logic [COL_W-1:0]  lc_idx;
  } store_cmd_t;

endpackage

[design/tdsr_store.sv]
`timescale 1ns / 1ps
// Row text memory, per-row non-blank flags and the copy of the line being drawn.
module tdsr_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tdsr_pkg::store_cmd_t      cmd,
  output logic [tdsr_pkg::ROWS-1:0] heads,
  output logic [7:0]                lc_char
);
  import tdsr_pkg::*;

  logic [CHAR_W-1:0] mem [MEM_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [CHAR_W-1:0] line_copy [PITCH];
  logic [ROWS-1:0]   head_nz_r;
  logic [ROWS-1:0]   head_nz_nxt;

  // Single-port row memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.mem_addr] <= cmd.mem_wdata;
    end
    if (cmd.mem_re) begin
      rd_data_r <= mem[cmd.mem_addr];
    end
  end

  // Line copy, filled from the read register
  always_ff @(posedge clk) begin
    if (cmd.copy_we) begin
      line_copy[cmd.copy_idx] <= cmd.copy_zero ? '0 : rd_data_r;
    end
  end

  // Row head flags: set when the first byte of a row is non-zero
  always_comb begin
    head_nz_nxt = head_nz_r;
    if (cmd.head_clr) begin
      head_nz_nxt = '0;
    end else if (cmd.head_we) begin
      head_nz_nxt[cmd.head_row] = cmd.head_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_nz_r <= '0;
    end else begin
      head_nz_r <= head_nz_nxt;
    end
  end

  assign heads   = head_nz_r;
  assign lc_char = line_copy[cmd.lc_idx];

endmodule

[design/text_display_scroll_refresher.sv]
`timescale 1ns / 1ps
// Top level of the text display scroll refresher: sequencer, walk unit and ports.
//
// Holds ROWS text rows of up to COLS characters and turns each refresh item that
// is not too early into one display operation (cursor command or one character).
// One item is handled at a time; in_tready is high only while the sequencer is
// idle, and a finished result sits in the output register while the next item is
// taken. Select and a refresh that is too early give no result. The blank-row walk
// checks one row per cycle through the shared row-advance unit, and the line copy
// reads the single-port row memory one byte per cycle. The output register then
// waits for out_tready.
module text_display_scroll_refresher (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tdsr_pkg::IN_DATA_W-1:0]     in_tdata,   // row_select, char_in, now_ms
  input  logic [tdsr_pkg::ACT_W-1:0]         in_tuser,   // action
  // Result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tdsr_pkg::OUT_DATA_W-1:0]    out_tdata,  // line, character, accepted, zeros
  output logic [tdsr_pkg::KIND_W-1:0]        out_tuser,  // kind
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [tdsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdsr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tdsr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_TERM   = 10'b0000000100,
    S_START  = 10'b0000001000,
    S_WALK   = 10'b0000010000,
    S_COPY   = 10'b0000100000,
    S_CHAR   = 10'b0001000000,
    S_PAGE   = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    RET_LINE = 2'd0,
    RET_EOL  = 2'd1,
    RET_PAGE = 2'd2
  } ret_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  // Configuration
  logic [LINES_W-1:0] lines_r;
  logic [MODE_W-1:0]  mode_r;
  logic [IVL_W-1:0]   interval_r;

  // Latched item
  logic [ACT_W-1:0]  act_r;
  logic [SEL_W-1:0]  sel_r;
  logic [CHAR_W-1:0] chr_r;
  logic [TIME_W-1:0] now_r;

  // Walk and draw state
  logic [SEL_W-1:0]  write_row_r, write_row_nxt;
  logic [COL_W-1:0]  write_col_r, write_col_nxt;
  logic              frs_valid_r, frs_valid_nxt;
  logic [ROW_W-1:0]  frs_r, frs_nxt;
  logic [ROW_W-1:0]  next_row_r, next_row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              exh_r, exh_nxt;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0]  copy_idx_r, copy_idx_nxt;
  logic              active_r, active_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [CP_W-1:0]   cp_r, cp_nxt;

  // Pending result and output register
  logic [KIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [LINE_W-1:0] pend_line_r, pend_line_nxt;
  logic [CHAR_W-1:0] pend_char_r, pend_char_nxt;
  logic              pend_acc_r, pend_acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [KIND_W-1:0] out_kind_r;
  logic [LINE_W-1:0] out_line_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_acc_r;

  // Shared row-advance unit
  logic [ROW_W-1:0]   adv_src;
  logic [ROW_W-1:0]   adv_next;
  logic               adv_exh;
  logic [MODE_W-1:0]  mode_eff;
  logic [LINES_W-1:0] lines_eff;
  logic [TIME_W-1:0]  elapsed;
  logic               too_early;
  logic [COL_W-1:0]   col_inc;
  logic [COL_W-1:0]   cp_prev;

  store_cmd_t      cmd;
  logic [ROWS-1:0] heads;
  logic [CHAR_W-1:0] lc_char;

  tdsr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .heads   (heads),
    .lc_char (lc_char)
  );

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(PITCH);
    return ADDR_W'(base + ADDR_W'(col));
  endfunction

  assign in_tready = (state_r == S_IDLE);

  // Effective settings
  assign mode_eff  = (mode_r == MODE_ALT) ? MODE_CONT : mode_r;
  assign lines_eff = (lines_r == '0) ? LINES_W'(1) :
                     ((lines_r > MAX_LINES) ? MAX_LINES : lines_r);

  // Interval check
  assign elapsed   = now_r - last_r;
  assign too_early = elapsed < TIME_W'(interval_r);

  // Row advance: wraps at ROWS, flags the walk done at page end or back at the first row
  always_comb begin
    if (state_r == S_PAGE) begin
      adv_src = frs_valid_r ? frs_r : LAST_ROW;
    end else begin
      adv_src = next_row_r;
    end
    adv_next = (adv_src == LAST_ROW) ? '0 : ROW_W'(adv_src + 1'b1);
    if (mode_eff == MODE_PAGE) begin
      adv_exh = (adv_next == '0);
    end else begin
      adv_exh = frs_valid_r && (adv_next == frs_r);
    end
  end

  assign col_inc = COL_W'(col_cnt_r + 1'b1);
  assign cp_prev = COL_W'(cp_r - 1'b1);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    write_row_nxt = write_row_r;
    write_col_nxt = write_col_r;
    frs_valid_nxt = frs_valid_r;
    frs_nxt       = frs_r;
    next_row_nxt  = next_row_r;
    slot_nxt      = slot_r;
    exh_nxt       = exh_r;
    col_cnt_nxt   = col_cnt_r;
    copy_idx_nxt  = copy_idx_r;
    active_nxt    = active_r;
    last_nxt      = last_r;
    steps_nxt     = steps_r;
    cp_nxt        = cp_r;
    pend_kind_nxt = pend_kind_r;
    pend_line_nxt = pend_line_r;
    pend_char_nxt = pend_char_r;
    pend_acc_nxt  = pend_acc_r;
    out_load      = 1'b0;

    cmd           = '0;
    cmd.lc_idx    = copy_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        pend_line_nxt = '0;
        pend_char_nxt = '0;
        pend_acc_nxt  = 1'b0;
        case (act_r)
          ACT_CLEAR: begin
            cmd.head_clr  = 1'b1;
            frs_valid_nxt = 1'b0;
            pend_kind_nxt = KIND_CLEAR;
            state_nxt     = S_EMIT;
          end
          ACT_SELECT: begin
            write_row_nxt = sel_r;
            write_col_nxt = '0;
            state_nxt     = S_IDLE;
          end
          ACT_APPEND: begin
            pend_kind_nxt = KIND_ACK;
            if (write_row_r >= SEL_W'(ROWS) || write_col_r >= COL_W'(COLS)) begin
              state_nxt = S_EMIT;
            end else begin
              cmd.mem_we    = 1'b1;
              cmd.mem_addr  = mem_addr(write_row_r[ROW_W-1:0], write_col_r);
              cmd.mem_wdata = chr_r;
              if (write_col_r == '0) begin
                cmd.head_we  = 1'b1;
                cmd.head_row = write_row_r[ROW_W-1:0];
                cmd.head_val = (chr_r != '0);
              end
              write_col_nxt = COL_W'(write_col_r + 1'b1);
              state_nxt     = S_TERM;
            end
          end
          ACT_REFRESH: begin
            if (too_early) begin
              state_nxt = S_IDLE;
            end else if (active_r) begin
              state_nxt = S_CHAR;
            end else begin
              state_nxt = S_START;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // Terminator after the appended byte
      S_TERM: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = mem_addr(write_row_r[ROW_W-1:0], write_col_r);
        cmd.mem_wdata = '0;
        pend_acc_nxt  = 1'b1;
        state_nxt     = S_EMIT;
      end

      // Line start: remember the first row of this screen
      S_START: begin
        if (!frs_valid_r) begin
          frs_valid_nxt = 1'b1;
          frs_nxt       = next_row_r;
        end
        steps_nxt = '0;
        ret_nxt   = RET_LINE;
        state_nxt = S_WALK;
      end

      // Blank-row walk, one row per cycle
      S_WALK: begin
        if (exh_r || heads[next_row_r]) begin
          case (ret_r)
            RET_LINE: begin
              if (exh_r) begin
                cmd.copy_we   = 1'b1;
                cmd.copy_zero = 1'b1;
                cmd.copy_idx  = '0;
                pend_kind_nxt = KIND_CURSOR;
                pend_line_nxt = slot_r[LINE_W-1:0];
                pend_char_nxt = '0;
                pend_acc_nxt  = 1'b0;
                col_cnt_nxt   = '0;
                copy_idx_nxt  = '0;
                active_nxt    = 1'b1;
                state_nxt     = S_EMIT;
              end else begin
                cp_nxt    = '0;
                state_nxt = S_COPY;
              end
            end
            RET_EOL:  state_nxt = S_PAGE;
            RET_PAGE: state_nxt = S_FIN;
            default:  state_nxt = S_FIN;
          endcase
        end else if (steps_r >= STEP_W'(ROWS)) begin
          exh_nxt = 1'b1;
        end else begin
          next_row_nxt = adv_next;
          exh_nxt      = adv_exh;
          steps_nxt    = STEP_W'(steps_r + 1'b1);
        end
      end

      // Copy the row into the line buffer; each byte is written in the cycle after its read
      S_COPY: begin
        if (cp_r < CP_W'(PITCH)) begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = mem_addr(next_row_r, cp_r[COL_W-1:0]);
        end
        if (cp_r != '0) begin
          cmd.copy_we  = 1'b1;
          cmd.copy_idx = cp_prev;
        end
        cp_nxt = CP_W'(cp_r + 1'b1);
        if (cp_r == CP_W'(PITCH)) begin
          pend_kind_nxt = KIND_CURSOR;
          pend_line_nxt = slot_r[LINE_W-1:0];
          pend_char_nxt = '0;
          pend_acc_nxt  = 1'b0;
          col_cnt_nxt   = '0;
          copy_idx_nxt  = '0;
          active_nxt    = 1'b1;
          state_nxt     = S_EMIT;
        end
      end

      // One character of the line, spaces once the text runs out
      S_CHAR: begin
        pend_kind_nxt = KIND_CHAR;
        pend_line_nxt = '0;
        pend_acc_nxt  = 1'b0;
        if (lc_char != '0) begin
          pend_char_nxt = lc_char;
          copy_idx_nxt  = COL_W'(copy_idx_r + 1'b1);
        end else begin
          pend_char_nxt = SPACE_CHAR;
        end
        col_cnt_nxt = col_inc;
        state_nxt   = S_PAGE;
        if (col_inc >= COL_W'(COLS)) begin
          slot_nxt   = SLOT_W'(slot_r + 1'b1);
          active_nxt = 1'b0;
          if (!exh_r) begin
            next_row_nxt = adv_next;
            exh_nxt      = adv_exh;
            steps_nxt    = '0;
            ret_nxt      = RET_EOL;
            state_nxt    = S_WALK;
          end
        end
      end

      // End of screen check; row mode steps past the first row shown
      S_PAGE: begin
        if (slot_r >= SLOT_W'(lines_eff)) begin
          if (mode_eff == MODE_ROW && !exh_r) begin
            next_row_nxt = adv_next;
            exh_nxt      = adv_exh;
            steps_nxt    = '0;
            ret_nxt      = RET_PAGE;
            state_nxt    = S_WALK;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_FIN: begin
        exh_nxt       = 1'b0;
        slot_nxt      = '0;
        frs_valid_nxt = 1'b0;
        last_nxt      = now_r;
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_LINE;
      lines_r     <= LINES_RST;
      mode_r      <= MODE_CONT;
      interval_r  <= INTERVAL_RST;
      write_row_r <= '0;
      write_col_r <= '0;
      frs_valid_r <= 1'b0;
      frs_r       <= '0;
      next_row_r  <= '0;
      slot_r      <= '0;
      exh_r       <= 1'b0;
      col_cnt_r   <= '0;
      copy_idx_r  <= '0;
      active_r    <= 1'b0;
      last_r      <= '0;
      steps_r     <= '0;
      cp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      write_row_r <= write_row_nxt;
      write_col_r <= write_col_nxt;
      frs_valid_r <= frs_valid_nxt;
      frs_r       <= frs_nxt;
      next_row_r  <= next_row_nxt;
      slot_r      <= slot_nxt;
      exh_r       <= exh_nxt;
      col_cnt_r   <= col_cnt_nxt;
      copy_idx_r  <= copy_idx_nxt;
      active_r    <= active_nxt;
      last_r      <= last_nxt;
      steps_r     <= steps_nxt;
      cp_r        <= cp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINES:    lines_r    <= cfg_wdata[LINES_W-1:0];
          CFG_MODE:     mode_r     <= cfg_wdata[MODE_W-1:0];
          CFG_INTERVAL: interval_r <= cfg_wdata[IVL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= in_tuser;
      sel_r <= in_tdata[SEL_W-1:0];
      chr_r <= in_tdata[SEL_W +: CHAR_W];
      now_r <= in_tdata[SEL_W+CHAR_W +: TIME_W];
    end
    pend_kind_r <= pend_kind_nxt;
    pend_line_r <= pend_line_nxt;
    pend_char_r <= pend_char_nxt;
    pend_acc_r  <= pend_acc_nxt;
    if (out_load) begin
      out_kind_r <= pend_kind_r;
      out_line_r <= pend_line_r;
      out_char_r <= pend_char_r;
      out_acc_r  <= pend_acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_DATA_W - LINE_W - CHAR_W - 1)'(0), out_acc_r, out_char_r,
                       out_line_r};

endmodule

[design/tdsr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the text display scroll refresher, bound to the top level.
module tdsr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [tdsr_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic [tdsr_pkg::ACT_W-1:0]         in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tdsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [tdsr_pkg::KIND_W-1:0]        out_tuser,
  input logic                               cfg_we,
  input logic [tdsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [tdsr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tdsr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The input is not ready in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted on back-to-back cycles");

  // Fields not used by a result kind read as zero
  a_unused_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_ACK || !out_tdata[11]) &&
                   (out_tuser == KIND_CURSOR || out_tdata[2:0] == 3'd0) &&
                   (out_tuser == KIND_CHAR || out_tdata[10:3] == 8'd0) &&
                   (out_tdata[15:12] == 4'd0))
    else $error("unused result field not zero");

  // A clear with a free output register shows its result after the decode and emit states
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_CLEAR && !out_tvalid |->
      ##3 out_tvalid && out_tuser == KIND_CLEAR)
    else $error("clear result missing");

endmodule

bind text_display_scroll_refresher tdsr_checker u_tdsr_checker (.*);
